[sv/fpr_pkg.sv]
// shared constants and types for the framed packet receiver
package fpr_pkg;

  localparam int PAYLOAD_DEPTH = 128;
  localparam int IDX_W = $clog2(PAYLOAD_DEPTH);
  localparam int CNT_W = $clog2(PAYLOAD_DEPTH + 1);

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE = 8'h03;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'd128;

  localparam int ADDR_W = 3;
  localparam logic [ADDR_W-3:0] REG_MAX_LENGTH = '0;

  typedef enum logic [1:0] {
    ST_GOOD = 2'd0,
    ST_BAD_LENGTH = 2'd1,
    ST_BAD_CHECKSUM = 2'd2,
    ST_BAD_END = 2'd3
  } status_t;

  typedef struct packed {
    status_t status;
    logic send_ack;
    logic [7:0] frame_length;
    logic [7:0] computed_sum;
  } result_t;

endpackage

[sv/framed_packet_receiver_top.sv]
// framed packet receiver: stx / length / payload / checksum / etx parser
//
// one received serial byte enters on the input channel (in_valid, in_stall,
// rx_data) and is taken at every clock edge with in_valid high and in_stall
// low, so the block runs at one byte per cycle. bytes are discarded until a
// start byte, then the length, payload, checksum and end byte are checked.
// each finished or failed frame gives one item on the output channel
// (out_valid, out_stall, status, send_ack, frame_length, computed_sum),
// registered at the edge that took the byte which ended the frame.
// a two-entry output stage (result register plus skid register) lets input
// continue while a result waits; in_stall rises only when both are full,
// i.e. after the receiver has held out_stall with a second result pending.
// the user writes max_length (apb port, address 0) only while idle; the block
// does not enforce this. length 0 or above min(max_length, 128) is rejected.
// synchronous reset returns to hunting for a start byte, empties the output
// stage and sets max_length to 128; the payload buffer is not cleared.
module framed_packet_receiver_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fpr_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rx_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic                       send_ack,
  output logic [7:0]                 frame_length,
  output logic [7:0]                 computed_sum
);
  import fpr_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_LEN,
    PH_DATA,
    PH_SUM,
    PH_END
  } phase_t;

  phase_t          phase, phase_next;
  logic [7:0]      max_length;
  logic [7:0]      length_held, length_held_next;
  logic [CNT_W-1:0] byte_index, byte_index_next;
  logic [7:0]      running_sum, running_sum_next;
  logic [7:0]      payload_store [PAYLOAD_DEPTH];

  result_t out_res, skid_res, res;
  logic    skid_valid;
  logic    res_fire;
  logic    accept;
  logic    out_free;
  logic    cfg_write;
  logic [7:0] limit;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (paddr[ADDR_W-1:2] == REG_MAX_LENGTH);
  assign prdata    = (paddr[ADDR_W-1:2] == REG_MAX_LENGTH) ? {24'd0, max_length} : 32'd0;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign limit = (max_length > 8'(PAYLOAD_DEPTH)) ? 8'(PAYLOAD_DEPTH) : max_length;

  always_comb begin
    phase_next       = phase;
    length_held_next = length_held;
    byte_index_next  = byte_index;
    running_sum_next = running_sum;
    res_fire         = 1'b0;
    res.status       = ST_GOOD;
    res.send_ack     = 1'b0;
    res.frame_length = length_held;
    res.computed_sum = running_sum;
    unique case (phase)
      PH_LEN: begin
        length_held_next = rx_data;
        byte_index_next  = '0;
        running_sum_next = 8'd0;
        if (rx_data == 8'd0 || rx_data > limit) begin
          res_fire         = 1'b1;
          res.status       = ST_BAD_LENGTH;
          res.frame_length = rx_data;
          res.computed_sum = 8'd0;
          phase_next       = PH_HUNT;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        running_sum_next = running_sum + rx_data;
        byte_index_next  = byte_index + CNT_W'(1);
        if (9'(byte_index_next) >= 9'(length_held)) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        if (rx_data != running_sum) begin
          res_fire   = 1'b1;
          res.status = ST_BAD_CHECKSUM;
          phase_next = PH_HUNT;
        end else begin
          phase_next = PH_END;
        end
      end
      PH_END: begin
        res_fire = 1'b1;
        if (rx_data != END_BYTE) begin
          res.status = ST_BAD_END;
        end else begin
          res.status   = ST_GOOD;
          res.send_ack = 1'b1;
        end
        phase_next = PH_HUNT;
      end
      default: begin
        phase_next = (rx_data == START_BYTE) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      length_held <= 8'd0;
      byte_index  <= '0;
      running_sum <= 8'd0;
      max_length  <= MAX_LENGTH_RESET;
      out_valid   <= 1'b0;
      skid_valid  <= 1'b0;
    end else begin
      if (cfg_write) begin
        max_length <= pwdata[7:0];
      end
      if (accept) begin
        phase       <= phase_next;
        length_held <= length_held_next;
        byte_index  <= byte_index_next;
        running_sum <= running_sum_next;
      end
      if (out_free) begin
        if (skid_valid) begin
          out_res    <= skid_res;
          out_valid  <= 1'b1;
          skid_valid <= 1'b0;
        end else if (accept && res_fire) begin
          out_res   <= res;
          out_valid <= 1'b1;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (accept && res_fire) begin
        skid_res   <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase == PH_DATA && byte_index < CNT_W'(PAYLOAD_DEPTH)) begin
      payload_store[byte_index[IDX_W-1:0]] <= rx_data;
    end
  end

  assign status       = out_res.status;
  assign send_ack     = out_res.send_ack;
  assign frame_length = out_res.frame_length;
  assign computed_sum = out_res.computed_sum;

`ifndef SYNTHESIS
  a_ack_only_good: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (send_ack == (status == ST_GOOD)))
    else $error("ack flag disagrees with status");

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register full with result register empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid register filled without a stalled result");

  a_length_in_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_BAD_LENGTH)
      |-> (frame_length != 8'd0 && frame_length <= 8'(PAYLOAD_DEPTH)))
    else $error("accepted frame with out of range length");
`endif

endmodule

[bench/tb.sv]
// self-checking testbench for the framed packet receiver
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fpr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam logic [ADDR_W-3:0] REG_UNUSED = 1'b1;
  localparam result_t NO_RES = '0;

  typedef enum logic [2:0] {P_HUNT, P_LEN, P_DATA, P_SUM, P_END} rx_phase_t;

  typedef struct {
    logic [7:0] rx;
    bit         typed;
    bit         gives;
    result_t    res;
  } dir_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [1:0]        status;
  logic              send_ack;
  logic [7:0]        frame_length;
  logic [7:0]        computed_sum;

  rx_phase_t  rx_phase = P_HUNT;
  logic [7:0] max_len = MAX_LENGTH_RESET;
  logic [7:0] len_held = '0;
  logic [7:0] byte_idx = '0;
  logic [7:0] run_sum = '0;

  result_t pending_results[$];
  int      fail_count = 0;
  int      cycle_count = 0;
  int      send_idle = 0;
  int      recv_idle = 0;

  dir_row_t dir_rows [24] = '{
    '{8'hFF, 1'b1, 1'b0, NO_RES},
    '{8'h03, 1'b1, 1'b0, NO_RES},
    '{8'h02, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, '{ST_BAD_LENGTH, 1'b0, 8'h00, 8'h00}},
    '{8'h02, 1'b1, 1'b0, NO_RES},
    '{8'h01, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b0, NO_RES},
    '{8'h03, 1'b1, 1'b1, '{ST_GOOD, 1'b1, 8'h01, 8'hFF}},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h03, 1'b0, 1'b0, NO_RES},
    '{8'h04, 1'b1, 1'b1, '{ST_BAD_CHECKSUM, 1'b0, 8'h02, 8'h05}},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h81, 1'b1, 1'b1, '{ST_BAD_LENGTH, 1'b0, 8'h81, 8'h00}},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'hFF, 1'b1, 1'b1, '{ST_BAD_LENGTH, 1'b0, 8'hFF, 8'h00}},
    '{8'h02, 1'b0, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b0, 1'b0, NO_RES},
    '{8'h02, 1'b1, 1'b1, '{ST_BAD_END, 1'b0, 8'h01, 8'h00}},
    '{8'h05, 1'b0, 1'b0, NO_RES}
  };

  framed_packet_receiver_top uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_data(rx_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .send_ack(send_ack),
    .frame_length(frame_length),
    .computed_sum(computed_sum)
  );

  always #5 clk = ~clk;

  function automatic void note_fail(input string msg);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  function automatic int length_limit();
    return (int'(max_len) > PAYLOAD_DEPTH) ? PAYLOAD_DEPTH : int'(max_len);
  endfunction

  // one received byte through the frame parser, returns 1 when a frame ends
  function automatic bit parse_rx_byte(input logic [7:0] b, output result_t r);
    r = NO_RES;
    case (rx_phase)
      P_LEN: begin
        len_held = b;
        byte_idx = '0;
        run_sum = '0;
        if (b == 8'd0 || int'(b) > length_limit()) begin
          r = '{ST_BAD_LENGTH, 1'b0, b, 8'h00};
          rx_phase = P_HUNT;
          return 1'b1;
        end
        rx_phase = P_DATA;
      end
      P_DATA: begin
        run_sum = run_sum + b;
        byte_idx = byte_idx + 8'd1;
        if (byte_idx >= len_held) rx_phase = P_SUM;
      end
      P_SUM: begin
        if (b != run_sum) begin
          r = '{ST_BAD_CHECKSUM, 1'b0, len_held, run_sum};
          rx_phase = P_HUNT;
          return 1'b1;
        end
        rx_phase = P_END;
      end
      P_END: begin
        if (b != END_BYTE) r = '{ST_BAD_END, 1'b0, len_held, run_sum};
        else r = '{ST_GOOD, 1'b1, len_held, run_sum};
        rx_phase = P_HUNT;
        return 1'b1;
      end
      default: begin
        rx_phase = (b == START_BYTE) ? P_LEN : P_HUNT;
      end
    endcase
    return 1'b0;
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit typed, input bit gives,
                           input result_t res);
    result_t r;
    bit      got;
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = parse_rx_byte(b, r);
    if (typed) begin
      if (gives) pending_results.push_back(res);
    end else if (got) begin
      pending_results.push_back(r);
    end
  endtask

  task automatic apb_access(input logic wr, input logic [ADDR_W-3:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic configure(input logic [ADDR_W-3:0] idx, input logic [31:0] value);
    logic [31:0] rd;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    apb_access(1'b1, idx, value, rd);
    if (idx == REG_MAX_LENGTH) max_len = value[7:0];
    apb_access(1'b0, REG_MAX_LENGTH, 32'd0, rd);
    if (rd !== {24'd0, max_len}) begin
      note_fail($sformatf("max_length readback: expected %0d, got %0d", max_len, rd));
    end
  endtask

  task automatic random_traffic(input int n_bytes, input bit full_frame);
    logic [7:0] chunk[$];
    logic [7:0] s;
    logic [7:0] d;
    int         lim;
    int         len;
    int         kind;
    int         done;
    bit         first;
    lim = length_limit();
    done = 0;
    first = full_frame && (lim > 0);
    while (done < n_bytes) begin
      kind = first ? 0 : int'($urandom_range(99));
      chunk.delete();
      if (kind >= 92) begin
        repeat ($urandom_range(1, 4)) chunk.push_back(8'($urandom_range(255)));
      end else if (kind >= 85) begin
        chunk.push_back(START_BYTE);
        if ($urandom_range(3) == 0) chunk.push_back(8'd0);
        else chunk.push_back(8'($urandom_range(255, lim + 1)));
      end else begin
        if (first) len = lim;
        else if (lim == 0) len = $urandom_range(1, 6);
        else if ($urandom_range(15) == 0) len = $urandom_range(1, lim);
        else len = $urandom_range(1, (lim < 6) ? lim : 6);
        chunk.push_back(START_BYTE);
        chunk.push_back(8'(len));
        s = '0;
        repeat (len) begin
          d = 8'($urandom_range(255));
          s = s + d;
          chunk.push_back(d);
        end
        if (kind >= 70 && kind < 78) s = s ^ 8'($urandom_range(1, 255));
        chunk.push_back(s);
        if (kind >= 78) begin
          d = ($urandom_range(3) == 0) ? START_BYTE : 8'($urandom_range(255));
          if (d == END_BYTE) d = 8'h00;
          chunk.push_back(d);
        end else begin
          chunk.push_back(END_BYTE);
        end
      end
      first = 1'b0;
      foreach (chunk[i]) send_byte(chunk[i], 1'b0, 1'b0, NO_RES);
      done += chunk.size();
    end
  endtask

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        note_fail($sformatf("unexpected result: status %0d ack %0d len %0d sum %0d",
                            status, send_ack, frame_length, computed_sum));
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status || send_ack !== want.send_ack ||
            frame_length !== want.frame_length || computed_sum !== want.computed_sum) begin
          note_fail($sformatf({"result mismatch: expected status %0d ack %0d len %0d sum %0d,",
                               " got status %0d ack %0d len %0d sum %0d"},
                              want.status, want.send_ack, want.frame_length,
                              want.computed_sum, status, send_ack, frame_length,
                              computed_sum));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int waited;
    send_idle = 27;
    recv_idle = 79;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].rx, dir_rows[i].typed, dir_rows[i].gives, dir_rows[i].res);
    end
    random_traffic(150, 1'b1);

    configure(REG_MAX_LENGTH, 32'd1);
    send_idle = 79;
    recv_idle = 27;
    random_traffic(90, 1'b1);

    configure(REG_MAX_LENGTH, 32'd255);
    send_idle = 0;
    recv_idle = 0;
    random_traffic(90, 1'b0);

    configure(REG_MAX_LENGTH, 32'd0);
    send_idle = 27;
    recv_idle = 79;
    random_traffic(50, 1'b0);

    configure(REG_MAX_LENGTH, 32'($urandom_range(2, 30)));
    send_idle = 79;
    recv_idle = 27;
    random_traffic(90, 1'b1);

    configure(REG_UNUSED, 32'($urandom_range(255)));
    send_idle = 0;
    recv_idle = 0;
    random_traffic(60, 1'b0);

    @(negedge clk);
    in_valid <= 1'b0;
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_fail($sformatf("%0d expected results never arrived", pending_results.size()));
    end
    if (fail_count == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
